// File: design/indexed_list_buffer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list buffer
// Checks on the local clock, switched off as a group by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_BUFFER_ASSERT_SVH
`define INDEXED_LIST_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define ILB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("indexed_list_buffer: assertion failed");

// condition must never be seen outside reset
`define ILB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("indexed_list_buffer: forbidden condition seen");

`else

`define ILB_ASSERT(lbl, prop)
`define ILB_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: design/ilb_pkg.sv
// ----------------------------------------------------------------------------
// ilb_pkg
// Sizes, request and status codes and sequencer states of the list buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ilb_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned AddrW    = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned PosW    = 10;
  localparam int unsigned StatW   = 2;
  localparam int unsigned LenW    = 11;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_STORE,
    S_PLACE,
    S_RESULT
  } state_e;

endpackage

`default_nettype wire

// File: design/indexed_list_buffer.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer
// Bounded ordered list of 32-bit values with head, tail and indexed access.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one item per handshake; each gives
//   exactly one item on the m_axis channel (status, value, length after).
//   s_axis_tready is high only while the block is idle; it drops for the
//   whole of a request and returns the cycle after the result is taken.
//   Append and every miss go straight to the result; read and pop first
//   load the entry from the store. Insert shifts the whole list one place
//   towards the tail, then writes the new value at the head; pop and
//   remove shift the entries behind the position one place towards the head.
//   Shifts move one entry at a time through the store's one read and one
//     write port (read an entry, then write it back one place on).
//   Reset empties the list at once; entries are not cleared and are never
//   returned before written. While m_axis_tready is low the result is held and
//   no new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_buffer_assert.svh"

module indexed_list_buffer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  // [2:0] mode, [34:3] value_in, [44:35] position, [47:45] zero
  input  wire logic [ilb_pkg::InDataW-1:0]  s_axis_tdata,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] status, [33:2] value_out, [44:34] length, [47:45] zero
  output      logic [ilb_pkg::OutDataW-1:0] m_axis_tdata
);

  import ilb_pkg::*;

  logic [ValW-1:0]  entries_q [CAPACITY];
  logic [ValW-1:0]  rdata_q;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  mode_e            op_q, op_d;
  logic [ValW-1:0]  val_q, val_d;
  status_e          status_q, status_d;
  logic [ValW-1:0]  result_q, result_d;

  logic [ModeW-1:0] in_mode;
  logic [ValW-1:0]  in_val;
  logic [PosW-1:0]  in_pos;
  logic             accept;
  logic             full, empty, pos_hit;
  logic             dir_up, more;
  logic [CntW-1:0]  step;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [ValW-1:0]  wdata;

  assign in_mode = s_axis_tdata[ModeW-1:0];
  assign in_val  = s_axis_tdata[ModeW +: ValW];
  assign in_pos  = s_axis_tdata[ModeW+ValW +: PosW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_RESULT);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full    = (count_q == CntW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign pos_hit = ({1'b0, in_pos} < LenW'(count_q));

  // shared index unit: one step towards the tail (drop) or the head (insert)
  assign dir_up = (op_q == MODE_INSERT);
  assign step   = dir_up ? (idx_q - CntW'(1)) : (idx_q + CntW'(1));
  assign more   = dir_up ? (idx_q != '0) : (step != count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_e'(in_mode))
            MODE_APPEND: state_d = S_RESULT;
            MODE_INSERT: state_d = full ? S_RESULT : S_FETCH;
            MODE_POP:    state_d = empty ? S_RESULT : S_LOAD;
            MODE_REMOVE: state_d = pos_hit ? S_FETCH : S_RESULT;
            MODE_READ:   state_d = pos_hit ? S_LOAD : S_RESULT;
            default:     state_d = S_RESULT;
          endcase
        end
      end
      S_LOAD:   state_d = (op_q == MODE_POP) ? S_FETCH : S_RESULT;
      S_FETCH: begin
        if (more) begin
          state_d = S_STORE;
        end else begin
          state_d = dir_up ? S_PLACE : S_RESULT;
        end
      end
      S_STORE:  state_d = S_FETCH;
      S_PLACE:  state_d = S_RESULT;
      S_RESULT: state_d = m_axis_tready ? S_IDLE : S_RESULT;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    op_d     = op_q;
    val_d    = val_q;
    status_d = status_q;
    result_d = result_q;
    we       = 1'b0;
    waddr    = count_q[AddrW-1:0];
    wdata    = in_val;
    raddr    = '0;
    unique case (state_q)
      S_IDLE: begin
        raddr = (mode_e'(in_mode) == MODE_READ) ? in_pos[AddrW-1:0] : '0;
        if (accept) begin
          op_d     = mode_e'(in_mode);
          val_d    = in_val;
          result_d = '0;
          status_d = ST_MISS;
          idx_d    = '0;
          unique case (mode_e'(in_mode))
            MODE_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                we       = 1'b1;
                count_d  = count_q + CntW'(1);
                status_d = ST_OK;
              end
            end
            MODE_INSERT: begin
              idx_d    = count_q;
              status_d = full ? ST_FULL : ST_OK;
            end
            MODE_POP: begin
              if (!empty) status_d = ST_OK;
            end
            MODE_REMOVE: begin
              idx_d = CntW'(in_pos[AddrW-1:0]);
              if (pos_hit) status_d = ST_OK;
            end
            MODE_READ: begin
              if (pos_hit) status_d = ST_OK;
            end
            default: status_d = ST_MISS;
          endcase
        end
      end
      S_LOAD: result_d = rdata_q;
      S_FETCH: begin
        raddr = step[AddrW-1:0];
        if (!more && !dir_up) count_d = count_q - CntW'(1);
      end
      S_STORE: begin
        we    = 1'b1;
        waddr = idx_q[AddrW-1:0];
        wdata = rdata_q;
        idx_d = step;
      end
      S_PLACE: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        count_d = count_q + CntW'(1);
      end
      S_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    op_q     <= op_d;
    val_q    <= val_d;
    status_q <= status_d;
    result_q <= result_d;
  end

  // list store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) entries_q[waddr] <= wdata;
    rdata_q <= entries_q[raddr];
  end

  assign m_axis_tdata = {{(OutDataW - StatW - ValW - LenW){1'b0}},
                         LenW'(count_q), result_q, status_q};

  `ILB_ASSERT_NEVER(a_count_bound, count_q > CntW'(CAPACITY))
  `ILB_ASSERT_NEVER(a_one_side, s_axis_tready && m_axis_tvalid)
  `ILB_ASSERT(a_ready_after_take, (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
  `ILB_ASSERT(a_full_len, (m_axis_tvalid && status_q == ST_FULL) |-> full)

endmodule

`default_nettype wire

// File: tb/indexed_list_buffer_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer_tb
// Drives list requests through the slave stream and checks every result item
// against a local model of the bounded list: directed corner cases first,
// then random bursts that push the list between empty and full under
// several idle and back-pressure patterns.
// ----------------------------------------------------------------------------
module indexed_list_buffer_tb;
  import ilb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 40;

  // spare request codes, answered with a miss
  localparam logic [ModeW-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [ValW-1:0]  value;
    logic [LenW-1:0]  length;
  } list_result_t;

  class list_scoreboard;
    logic [ValW-1:0] slots [CAPACITY];
    int unsigned     fill;
    list_result_t    expected [$];
    int unsigned     mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function void drop_slot(int unsigned pos);
      for (int unsigned i = pos; i + 1 < fill; i++)
        slots[i] = slots[i + 1];
      fill--;
    endfunction

    // works out the result of one accepted request and queues it
    function void note_request(logic [InDataW-1:0] d);
      logic [ModeW-1:0] mode;
      logic [ValW-1:0]  val;
      logic [PosW-1:0]  pos;
      list_result_t     r;
      mode     = d[2:0];
      val      = d[34:3];
      pos      = d[44:35];
      r.status = ST_MISS;
      r.value  = '0;
      case (mode)
        MODE_APPEND: begin
          if (fill == CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = val;
            fill++;
            r.status = ST_OK;
          end
        end
        MODE_INSERT: begin
          if (fill == CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int unsigned i = fill; i > 0; i--)
              slots[i] = slots[i - 1];
            slots[0] = val;
            fill++;
            r.status = ST_OK;
          end
        end
        MODE_POP: begin
          if (fill > 0) begin
            r.value = slots[0];
            drop_slot(0);
            r.status = ST_OK;
          end
        end
        MODE_REMOVE: begin
          if (pos < fill) begin
            drop_slot(pos);
            r.status = ST_OK;
          end
        end
        MODE_READ: begin
          if (pos < fill) begin
            r.value  = slots[pos];
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      r.length = fill[LenW-1:0];
      expected.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      list_result_t got;
      list_result_t want;
      bit           bad;
      got.status = d[1:0];
      got.value  = d[33:2];
      got.length = d[44:34];
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: status %0d value %h length %0d",
                   got.status, got.value, got.length);
        return;
      end
      want = expected.pop_front();
      bad  = 0;
      if (got.status !== want.status) bad = 1;
      if (got.value !== want.value) bad = 1;
      if (got.length !== want.length) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch: expected status %0d value %h length %0d, ",
                 want.status, want.value, want.length);
          $display("got status %0d value %h length %0d",
                   got.status, got.value, got.length);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  list_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    rx_stall_pct = 0;
  bit             hold_req = 0;

  indexed_list_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_list_buffer_tb failed");
      $finish;
    end
  end

  // result first: the block never takes a request on the edge a result leaves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [InDataW-1:0] pack_request(logic [ModeW-1:0] m,
                                                      logic [ValW-1:0] v,
                                                      logic [PosW-1:0] p);
    return {3'b000, p, v, m};
  endfunction

  task automatic offer(input logic [InDataW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [InDataW-1:0] random_request(int unsigned grow_pct);
    int unsigned      pick;
    logic [ModeW-1:0] m;
    logic [ValW-1:0]  v;
    logic [PosW-1:0]  p;
    pick = $urandom_range(99);
    if (pick < 3) begin
      case ($urandom_range(2))
        0:       m = MODE_SPARE5;
        1:       m = MODE_SPARE6;
        default: m = MODE_SPARE7;
      endcase
    end else if (pick < 3 + grow_pct) begin
      m = $urandom_range(1) ? MODE_APPEND : MODE_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       m = MODE_POP;
        1:       m = MODE_REMOVE;
        default: m = MODE_READ;
      endcase
    end
    case ($urandom_range(7))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'h0000_0000;
      3:       v = 32'hffff_ffff;
      default: v = $urandom;
    endcase
    // mostly positions near the live range, now and then anywhere
    if ($urandom_range(9) == 0) p = PosW'($urandom);
    else p = PosW'($urandom_range(CAPACITY + 1));
    return pack_request(m, v, p);
  endfunction

  initial begin
    int unsigned send_pcts [4];
    int unsigned stall_pcts [4];
    int unsigned grow_pct;
    send_pcts  = '{0, 57, 0, 13};
    stall_pcts = '{0, 0, 57, 13};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    rx_stall_pct = 30;

    // empty list, spare codes
    offer(pack_request(MODE_POP, $urandom, PosW'($urandom)));
    offer(pack_request(MODE_READ, $urandom, 10'd0));
    offer(pack_request(MODE_REMOVE, $urandom, 10'd1023));
    offer(pack_request(MODE_SPARE5, 32'hffff_ffff, 10'd1023));
    offer(pack_request(MODE_SPARE6, 32'h0, 10'd0));
    offer(pack_request(MODE_SPARE7, $urandom, PosW'($urandom)));
    // fill to capacity from both ends
    offer(pack_request(MODE_APPEND, 32'h7fff_ffff, PosW'($urandom)));
    offer(pack_request(MODE_INSERT, 32'h8000_0000, PosW'($urandom)));
    offer(pack_request(MODE_APPEND, 32'h0, PosW'($urandom)));
    offer(pack_request(MODE_INSERT, 32'hffff_ffff, PosW'($urandom)));
    for (int i = 4; i < CAPACITY; i++)
      offer(pack_request((i % 2) ? MODE_INSERT : MODE_APPEND, $urandom, PosW'($urandom)));
    // full list refuses appends and inserts; then reads, removes and a pop
    offer(pack_request(MODE_APPEND, $urandom, PosW'($urandom)));
    offer(pack_request(MODE_INSERT, $urandom, PosW'($urandom)));
    offer(pack_request(MODE_READ, $urandom, PosW'(CAPACITY - 1)));
    offer(pack_request(MODE_READ, $urandom, 10'd1023));
    offer(pack_request(MODE_REMOVE, $urandom, PosW'(CAPACITY - 1)));
    offer(pack_request(MODE_REMOVE, $urandom, 10'd0));
    offer(pack_request(MODE_POP, $urandom, PosW'($urandom)));
    drain();

    grow_pct = 45;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pcts[ph];
      rx_stall_pct  = stall_pcts[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bursts that lean towards growing, shrinking or neither
        if (n % 20 == 0) begin
          case ($urandom_range(2))
            0:       grow_pct = 70;
            1:       grow_pct = 45;
            default: grow_pct = 20;
          endcase
        end
        if (ph == 0 && n == 100) hold_req = 1;
        offer(random_request(grow_pct));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("indexed_list_buffer_tb passed");
    end else begin
      $display("indexed_list_buffer_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/ilb_pkg.sv
design/indexed_list_buffer.sv
tb/indexed_list_buffer_tb.sv
